>>> sv/cidac_pkg.sv
// Shared types, codes and constants of the card-ID access controller.
// No dependencies; imported by cidac_cell, cidac_ctrl and the top level.
package cidac_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_IDS_DEF     = 5;
  localparam int unsigned ID_CHARS_DEF    = 10;
  localparam int unsigned TIMER_WIDTH_DEF = 16;

  // Configuration port
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SESSION_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_TICKS = 1'd1;
  localparam logic [CFG_W-1:0] SESSION_TICKS_RST = 16'd1000;
  localparam logic [CFG_W-1:0] MESSAGE_TICKS_RST = 16'd500;

  // Entries present after reset: the administrator first, then one user
  localparam int unsigned RESET_IDS  = 2;
  localparam int unsigned SEED_CHARS = 10;
  localparam logic [8*SEED_CHARS-1:0] ADMIN_ID = "12345admin";
  localparam logic [8*SEED_CHARS-1:0] USER_ID  = "12345aaaaa";

  typedef enum logic [1:0] {
    OP_CHAR   = 2'd0,
    OP_TICK   = 2'd1,
    OP_BUTTON = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_ENROLL  = 3'd1,
    MODE_SESSION = 3'd2,
    MODE_MESSAGE = 3'd3,
    MODE_ADDED   = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    DISP_PROMPT     = 3'd0,
    DISP_VALID      = 3'd1,
    DISP_PROMPT_NEW = 3'd2,
    DISP_ADDED      = 3'd3,
    DISP_KNOWN      = 3'd4,
    DISP_WRONG      = 3'd5
  } disp_e;

  typedef enum logic [3:0] {
    EV_NONE        = 4'd0,
    EV_VALID       = 4'd1,
    EV_INVALID     = 4'd2,
    EV_ADMIN_START = 4'd3,
    EV_ADMIN_END   = 4'd4,
    EV_EXISTS      = 4'd5,
    EV_ADDED       = 4'd6,
    EV_BAD_LENGTH  = 4'd7,
    EV_TABLE_FULL  = 4'd8
  } event_e;

  typedef enum logic {
    CTL_READY  = 1'b0,
    CTL_SEARCH = 1'b1
  } ctl_state_e;

  // Search token handed from cell to cell
  typedef struct packed {
    logic active;
    logic found;
    logic admin;
  } srch_t;

  // Reset character of a stored entry, zero past the seed string
  function automatic logic [7:0] seed_char(int unsigned entry, int unsigned pos);
    logic [7:0] c;
    c = 8'h00;
    if (pos < SEED_CHARS) begin
      if (entry == 0) begin
        c = ADMIN_ID[8*(SEED_CHARS-1-pos) +: 8];
      end else if (entry == 1) begin
        c = USER_ID[8*(SEED_CHARS-1-pos) +: 8];
      end
    end
    return c;
  endfunction

endpackage

>>> sv/cidac_cell.sv
// One ID store cell: holds a table entry and compares it against the
// collected ID as the search token passes. Depends on cidac_pkg.
module cidac_cell #(
  parameter int unsigned MAX_IDS    = cidac_pkg::MAX_IDS_DEF,
  parameter int unsigned ID_CHARS   = cidac_pkg::ID_CHARS_DEF,
  parameter int unsigned CELL_INDEX = 0
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [ID_CHARS-1:0][7:0]           id_i,
  input  logic                               add_i,
  input  logic [$clog2(MAX_IDS+1)-1:0]       count_i,
  input  cidac_pkg::srch_t                   srch_i,
  output cidac_pkg::srch_t                   srch_o
);
  import cidac_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_IDS + 1);

  logic [ID_CHARS-1:0][7:0] entry_q;
  logic                     valid_q;
  srch_t                    srch_q, srch_d;
  logic                     wr_en;
  logic                     hit;

  assign wr_en = add_i && (count_i == CNT_W'(CELL_INDEX));
  assign hit   = srch_i.active && valid_q && (entry_q == id_i);

  always_comb begin
    srch_d.active = srch_i.active;
    srch_d.found  = srch_i.found | hit;
    // only the first entry is the administrator, and only as first match
    srch_d.admin  = srch_i.admin | (hit && (CELL_INDEX == 0) && !srch_i.found);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= (CELL_INDEX < RESET_IDS);
      srch_q  <= '0;
      for (int p = 0; p < ID_CHARS; p++) begin
        entry_q[p] <= seed_char(CELL_INDEX, p);
      end
    end else begin
      srch_q <= srch_d;
      if (wr_en) begin
        entry_q <= id_i;
        valid_q <= 1'b1;
      end
    end
  end

  assign srch_o = srch_q;

endmodule

>>> sv/cidac_ctrl.sv
// Mode controller: ID collection buffer, timer, configuration registers,
// result registers and the search sequencing. Depends on cidac_pkg.
module cidac_ctrl #(
  parameter int unsigned MAX_IDS     = cidac_pkg::MAX_IDS_DEF,
  parameter int unsigned ID_CHARS    = cidac_pkg::ID_CHARS_DEF,
  parameter int unsigned TIMER_WIDTH = cidac_pkg::TIMER_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [1:0]                          op_i,
  input  logic [7:0]                          card_char_i,
  output logic                                busy_o,
  input  logic                                cfg_we_i,
  input  logic [cidac_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cidac_pkg::CFG_W-1:0]         cfg_data_i,
  output logic [ID_CHARS-1:0][7:0]            id_o,
  output logic                                add_o,
  output logic [$clog2(MAX_IDS+1)-1:0]        count_o,
  output logic                                launch_o,
  input  cidac_pkg::srch_t                    srch_i,
  output logic                                done_o,
  output logic                                echo_valid_o,
  output logic [7:0]                          echo_char_o,
  output logic                                display_update_o,
  output logic [2:0]                          screen_code_o,
  output logic [3:0]                          event_code_o,
  output logic                                admin_active_o,
  output logic [2:0]                          mode_now_o
);
  import cidac_pkg::*;

  localparam int unsigned LEN_W = $clog2(ID_CHARS + 1);
  localparam int unsigned CNT_W = $clog2(MAX_IDS + 1);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(ID_CHARS);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_IDS);

  ctl_state_e               state_q, state_d;
  op_e                      op_q, op_in, cur_op;
  mode_e                    mode_q, mode_d;
  disp_e                    disp_q, disp_d;
  event_e                   ev_q, ev_d;
  logic                     admin_q, admin_d;
  logic [LEN_W-1:0]         len_q, len_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [TIMER_WIDTH-1:0]   timer_q, timer_d, timer_dec;
  logic [CFG_W-1:0]         sess_q, msg_q;
  logic [ID_CHARS-1:0][7:0] idbuf_q;
  logic                     echo_v_q, echo_v_d;
  logic [7:0]               echo_c_q, echo_c_d;
  logic                     upd_q, upd_d;
  logic                     done_q;
  logic                     accept, need_search, apply, idbuf_we, add;

  assign op_in  = op_e'(op_i);
  assign accept = start_i && (state_q == CTL_READY);
  assign busy_o = (state_q != CTL_READY);

  // A complete ID is checked against the table on an idle tick or an enroll button
  assign need_search = (len_q == LEN_FULL) &&
                       (((op_in == OP_TICK) && (mode_q == MODE_IDLE)) ||
                        ((op_in == OP_BUTTON) && (mode_q == MODE_ENROLL)));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CTL_READY: begin
        if (accept && need_search) state_d = CTL_SEARCH;
      end
      CTL_SEARCH: begin
        if (srch_i.active) state_d = CTL_READY;
      end
      default: state_d = CTL_READY;
    endcase
  end

  // sequencer outputs
  always_comb begin
    launch_o = 1'b0;
    apply    = 1'b0;
    cur_op   = op_in;
    unique case (state_q)
      CTL_READY: begin
        launch_o = accept && need_search;
        apply    = accept && !need_search;
      end
      CTL_SEARCH: begin
        cur_op = op_q;
        apply  = srch_i.active;
      end
      default: ;
    endcase
  end

  assign timer_dec = (timer_q != '0) ? timer_q - TIMER_WIDTH'(1) : timer_q;

  // effect of one item
  always_comb begin
    mode_d   = mode_q;
    disp_d   = disp_q;
    admin_d  = admin_q;
    len_d    = len_q;
    count_d  = count_q;
    timer_d  = timer_q;
    echo_v_d = 1'b0;
    echo_c_d = 8'h00;
    upd_d    = 1'b0;
    ev_d     = EV_NONE;
    idbuf_we = 1'b0;
    add      = 1'b0;
    case (cur_op)
      OP_CHAR: begin
        if ((mode_q == MODE_IDLE || mode_q == MODE_ENROLL) && (len_q < LEN_FULL)) begin
          idbuf_we = 1'b1;
          len_d    = len_q + LEN_W'(1);
          echo_v_d = 1'b1;
          echo_c_d = card_char_i;
        end
      end
      OP_TICK: begin
        if (mode_q == MODE_IDLE) begin
          if (len_q == LEN_FULL) begin
            if (srch_i.found) begin
              disp_d  = DISP_VALID;
              upd_d   = 1'b1;
              ev_d    = srch_i.admin ? EV_ADMIN_START : EV_VALID;
              admin_d = admin_q | srch_i.admin;
              timer_d = TIMER_WIDTH'(sess_q);
              mode_d  = MODE_SESSION;
            end else begin
              ev_d = EV_INVALID;
            end
            len_d = '0;
          end
        end else if (mode_q == MODE_SESSION || mode_q == MODE_MESSAGE ||
                     mode_q == MODE_ADDED) begin
          timer_d = timer_dec;
          if (timer_dec == '0) begin
            len_d = '0;
            upd_d = 1'b1;
            if (mode_q == MODE_SESSION) begin
              disp_d = DISP_PROMPT;
              mode_d = MODE_IDLE;
              if (admin_q) begin
                admin_d = 1'b0;
                ev_d    = EV_ADMIN_END;
              end
            end else if (mode_q == MODE_MESSAGE) begin
              disp_d = DISP_PROMPT_NEW;
              mode_d = MODE_ENROLL;
            end else begin
              disp_d = DISP_PROMPT;
              mode_d = MODE_IDLE;
            end
          end
        end
      end
      OP_BUTTON: begin
        upd_d = 1'b1;
        len_d = '0;
        if (mode_q == MODE_SESSION && admin_q) begin
          timer_d = '0;
          mode_d  = MODE_ENROLL;
          disp_d  = DISP_PROMPT_NEW;
        end else if (mode_q == MODE_ENROLL) begin
          if (len_q == '0) begin
            mode_d  = MODE_IDLE;
            admin_d = 1'b0;
            ev_d    = EV_ADMIN_END;
            disp_d  = DISP_PROMPT;
          end else if (len_q == LEN_FULL) begin
            timer_d = TIMER_WIDTH'(msg_q);
            mode_d  = MODE_MESSAGE;
            if (srch_i.found) begin
              disp_d = DISP_KNOWN;
              ev_d   = EV_EXISTS;
            end else if (count_q >= CNT_FULL) begin
              admin_d = 1'b0;
              disp_d  = DISP_WRONG;
              ev_d    = EV_TABLE_FULL;
            end else begin
              add     = 1'b1;
              count_d = count_q + CNT_W'(1);
              admin_d = 1'b0;
              mode_d  = MODE_ADDED;
              disp_d  = DISP_ADDED;
              ev_d    = EV_ADDED;
            end
          end else begin
            admin_d = 1'b0;
            mode_d  = MODE_MESSAGE;
            disp_d  = DISP_WRONG;
            ev_d    = EV_BAD_LENGTH;
            timer_d = TIMER_WIDTH'(msg_q);
          end
        end else begin
          mode_d = MODE_IDLE;
          disp_d = DISP_PROMPT;
          if (admin_q) begin
            admin_d = 1'b0;
            ev_d    = EV_ADMIN_END;
          end
        end
      end
      default: ;  // unused op: report present state
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= CTL_READY;
      op_q     <= OP_CHAR;
      mode_q   <= MODE_IDLE;
      disp_q   <= DISP_PROMPT;
      admin_q  <= 1'b0;
      len_q    <= '0;
      count_q  <= CNT_W'(RESET_IDS);
      timer_q  <= '0;
      sess_q   <= SESSION_TICKS_RST;
      msg_q    <= MESSAGE_TICKS_RST;
      done_q   <= 1'b0;
      echo_v_q <= 1'b0;
      echo_c_q <= 8'h00;
      upd_q    <= 1'b0;
      ev_q     <= EV_NONE;
    end else begin
      state_q <= state_d;
      done_q  <= apply;
      if (launch_o) op_q <= op_in;
      if (cfg_we_i && cfg_idx_i == REG_SESSION_TICKS) sess_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == REG_MESSAGE_TICKS) msg_q <= cfg_data_i;
      if (apply) begin
        mode_q   <= mode_d;
        disp_q   <= disp_d;
        admin_q  <= admin_d;
        len_q    <= len_d;
        count_q  <= count_d;
        timer_q  <= timer_d;
        echo_v_q <= echo_v_d;
        echo_c_q <= echo_c_d;
        upd_q    <= upd_d;
        ev_q     <= ev_d;
      end
    end
  end

  // Collection buffer: payload only, undefined until written
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ID_CHARS; i++) begin
      if (apply && idbuf_we && (len_q == LEN_W'(i))) idbuf_q[i] <= card_char_i;
    end
  end

  assign id_o             = idbuf_q;
  assign add_o            = apply && add;
  assign count_o          = count_q;
  assign done_o           = done_q;
  assign echo_valid_o     = echo_v_q;
  assign echo_char_o      = echo_c_q;
  assign display_update_o = upd_q;
  assign screen_code_o    = disp_q;
  assign event_code_o     = ev_q;
  assign admin_active_o   = admin_q;
  assign mode_now_o       = mode_q;

  a_token_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    srch_i.active |-> state_q == CTL_SEARCH)
    else $error("search token arrived outside a search");

  a_search_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CTL_SEARCH && srch_i.active) |=> done_q && state_q == CTL_READY)
    else $error("search finished without a result strobe");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_FULL)
    else $error("ID length beyond ID size");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL && count_q >= CNT_W'(RESET_IDS))
    else $error("ID count out of range");

  a_admin_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    admin_q |-> (mode_q == MODE_SESSION || mode_q == MODE_ENROLL ||
                 mode_q == MODE_MESSAGE))
    else $error("admin flag held in idle or added mode");

endmodule

>>> sv/card_id_access_controller.sv
// Top level of the card-ID access controller: controller plus the row of
// ID store cells. Depends on cidac_pkg, cidac_cell and cidac_ctrl.
//
// Usage:
//   Items enter on start_i with op_i (character, tick, button) and
//   card_char_i; an item is taken at a clock edge where start_i is high and
//   busy_o is low. Each item gives exactly one result, shown for one cycle
//   with done_o high; the receiver cannot hold it off.
//   Most items are applied in the transfer cycle and done_o is registered. A tick in
//   idle mode or a button in enroll mode with a complete ID walks the search
//   token through the MAX_IDS cells, one per cycle, and the result follows
//   once the token leaves the last cell; busy_o is high during the walk.
//   A new item may be taken in the cycle that shows the previous result.
//   Configuration: cfg_we_i, cfg_idx_i (0 session ticks, 1 message ticks)
//   and cfg_data_i, written at once; write only while no item is pending.
//   Reset (rst_ni low) returns to idle with the administrator and one user
//   ID stored, both tick registers at their defaults and no result pending.
module card_id_access_controller #(
  parameter int unsigned MAX_IDS     = cidac_pkg::MAX_IDS_DEF,
  parameter int unsigned ID_CHARS    = cidac_pkg::ID_CHARS_DEF,
  parameter int unsigned TIMER_WIDTH = cidac_pkg::TIMER_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [1:0]                      op_i,
  input  logic [7:0]                      card_char_i,
  input  logic                            cfg_we_i,
  input  logic [cidac_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cidac_pkg::CFG_W-1:0]     cfg_data_i,
  output logic                            done_o,
  output logic                            echo_valid_o,
  output logic [7:0]                      echo_char_o,
  output logic                            display_update_o,
  output logic [2:0]                      screen_code_o,
  output logic [3:0]                      event_code_o,
  output logic                            admin_active_o,
  output logic [2:0]                      mode_now_o
);
  import cidac_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_IDS + 1);

  logic [ID_CHARS-1:0][7:0] id;
  logic                     add;
  logic [CNT_W-1:0]         count;
  logic                     launch;
  srch_t                    head;
  srch_t                    chain [MAX_IDS];

  assign head.active = launch;
  assign head.found  = 1'b0;
  assign head.admin  = 1'b0;

  cidac_ctrl #(
    .MAX_IDS     (MAX_IDS),
    .ID_CHARS    (ID_CHARS),
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .op_i             (op_i),
    .card_char_i      (card_char_i),
    .busy_o           (busy_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .id_o             (id),
    .add_o            (add),
    .count_o          (count),
    .launch_o         (launch),
    .srch_i           (chain[MAX_IDS-1]),
    .done_o           (done_o),
    .echo_valid_o     (echo_valid_o),
    .echo_char_o      (echo_char_o),
    .display_update_o (display_update_o),
    .screen_code_o    (screen_code_o),
    .event_code_o     (event_code_o),
    .admin_active_o   (admin_active_o),
    .mode_now_o       (mode_now_o)
  );

  for (genvar c = 0; c < MAX_IDS; c++) begin : g_cell
    srch_t srch_in;
    if (c == 0) begin : g_first
      assign srch_in = head;
    end else begin : g_next
      assign srch_in = chain[c-1];
    end
    cidac_cell #(
      .MAX_IDS    (MAX_IDS),
      .ID_CHARS   (ID_CHARS),
      .CELL_INDEX (c)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .id_i    (id),
      .add_i   (add),
      .count_i (count),
      .srch_i  (srch_in),
      .srch_o  (chain[c])
    );
  end

endmodule

>>> tb/testbench.sv
// Self-checking testbench for card_id_access_controller: random and directed
// card, tick and button traffic, checked against an in-bench access predictor.
// Depends on cidac_pkg and the RTL of the controller only.
`timescale 1ns / 100ps

module testbench;
  import cidac_pkg::*;

  localparam int unsigned ID_LEN     = cidac_pkg::ID_CHARS_DEF;
  localparam int unsigned TABLE_SIZE = cidac_pkg::MAX_IDS_DEF;
  localparam int unsigned QUIET_MAX  = 1000;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;

  typedef logic [8*ID_LEN-1:0] card_id_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
  } card_item_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic       display_update;
    disp_e      screen_code;
    event_e     event_code;
    logic       admin_active;
    mode_e      mode_now;
  } access_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [1:0] op_i = OP_CHAR;
  logic [7:0] card_char_i = 8'h00;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_SESSION_TICKS;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic busy_o, done_o, echo_valid_o, display_update_o, admin_active_o;
  logic [7:0] echo_char_o;
  logic [2:0] screen_code_o, mode_now_o;
  logic [3:0] event_code_o;

  card_item_t  items_to_send [$];
  access_rsp_t reports_due [$];
  card_id_t    card_pool [$];
  int unsigned items_queued = 0;
  int unsigned errors = 0;
  int unsigned send_gap = 0;
  int unsigned quiet_cycles = 0;
  bit          gaps_on = 1'b1;
  card_item_t  next_item;
  access_rsp_t due;

  // Predicted controller state
  mode_e       cur_mode;
  logic        admin_on;
  card_id_t    id_buf;
  int unsigned id_len;
  card_id_t    card_table [TABLE_SIZE];
  int unsigned card_count;
  logic [15:0] tick_left;
  logic        tick_done;
  disp_e       shown;
  logic [15:0] session_len;
  logic [15:0] message_len;

  card_id_access_controller i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .op_i             (op_i),
    .card_char_i      (card_char_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .done_o           (done_o),
    .echo_valid_o     (echo_valid_o),
    .echo_char_o      (echo_char_o),
    .display_update_o (display_update_o),
    .screen_code_o    (screen_code_o),
    .event_code_o     (event_code_o),
    .admin_active_o   (admin_active_o),
    .mode_now_o       (mode_now_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned lookup_card();
    int unsigned k;
    for (k = 0; k < card_count; k++) begin
      if (card_table[k] == id_buf) return k;
    end
    return card_count;
  endfunction

  function automatic void arm_timer(input logic [15:0] ticks);
    tick_left = ticks;
    tick_done = 1'b0;
  endfunction

  // Advance the predicted controller by one item and return its report
  function automatic access_rsp_t predict_report(input logic [1:0] op, input logic [7:0] ch);
    access_rsp_t r;
    int unsigned k;
    r = '0;
    case (op)
      OP_CHAR: begin
        if ((cur_mode == MODE_IDLE || cur_mode == MODE_ENROLL) && id_len < ID_LEN) begin
          id_buf[8*(ID_LEN-1-id_len) +: 8] = ch;
          id_len++;
          r.echo_valid = 1'b1;
          r.echo_char = ch;
        end
      end
      OP_TICK: begin
        if (cur_mode == MODE_IDLE) begin
          if (id_len == ID_LEN) begin
            k = lookup_card();
            if (k < card_count) begin
              shown = DISP_VALID;
              r.display_update = 1'b1;
              if (k == 0) begin
                admin_on = 1'b1;
                r.event_code = EV_ADMIN_START;
              end else begin
                r.event_code = EV_VALID;
              end
              arm_timer(session_len);
              cur_mode = MODE_SESSION;
            end else begin
              r.event_code = EV_INVALID;
            end
            id_len = 0;
          end
        end else if (cur_mode == MODE_SESSION || cur_mode == MODE_MESSAGE ||
                     cur_mode == MODE_ADDED) begin
          if (tick_left != 0) tick_left--;
          if (tick_left == 0) tick_done = 1'b1;
          if (tick_done) begin
            tick_done = 1'b0;
            id_len = 0;
            r.display_update = 1'b1;
            case (cur_mode)
              MODE_SESSION: begin
                shown = DISP_PROMPT;
                cur_mode = MODE_IDLE;
                if (admin_on) begin
                  admin_on = 1'b0;
                  r.event_code = EV_ADMIN_END;
                end
              end
              MODE_MESSAGE: begin
                shown = DISP_PROMPT_NEW;
                cur_mode = MODE_ENROLL;
              end
              default: begin
                shown = DISP_PROMPT;
                cur_mode = MODE_IDLE;
              end
            endcase
          end
        end
      end
      OP_BUTTON: begin
        r.display_update = 1'b1;
        if (cur_mode == MODE_SESSION && admin_on) begin
          tick_left = '0;
          tick_done = 1'b0;
          cur_mode = MODE_ENROLL;
          shown = DISP_PROMPT_NEW;
        end else if (cur_mode == MODE_ENROLL) begin
          if (id_len == 0) begin
            cur_mode = MODE_IDLE;
            admin_on = 1'b0;
            r.event_code = EV_ADMIN_END;
            shown = DISP_PROMPT;
          end else if (id_len == ID_LEN) begin
            k = lookup_card();
            if (k < card_count) begin
              cur_mode = MODE_MESSAGE;
              shown = DISP_KNOWN;
              r.event_code = EV_EXISTS;
            end else if (card_count >= TABLE_SIZE) begin
              admin_on = 1'b0;
              cur_mode = MODE_MESSAGE;
              shown = DISP_WRONG;
              r.event_code = EV_TABLE_FULL;
            end else begin
              card_table[card_count] = id_buf;
              card_count++;
              admin_on = 1'b0;
              cur_mode = MODE_ADDED;
              shown = DISP_ADDED;
              r.event_code = EV_ADDED;
            end
            arm_timer(message_len);
          end else begin
            admin_on = 1'b0;
            cur_mode = MODE_MESSAGE;
            shown = DISP_WRONG;
            r.event_code = EV_BAD_LENGTH;
            arm_timer(message_len);
          end
        end else begin
          cur_mode = MODE_IDLE;
          shown = DISP_PROMPT;
          if (admin_on) begin
            admin_on = 1'b0;
            r.event_code = EV_ADMIN_END;
          end
        end
        id_len = 0;
      end
      default: ;
    endcase
    r.screen_code = shown;
    r.admin_active = admin_on;
    r.mode_now = cur_mode;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Driver: present queued items, hold while busy, idle for random gaps between transfers
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        reports_due.push_back(predict_report(op_i, card_char_i));
        send_gap = pick_gap();
      end
      if (start_i && busy_o) begin
        start_i <= 1'b1;
      end else if (send_gap != 0) begin
        send_gap--;
        start_i <= 1'b0;
      end else if (items_to_send.size() != 0) begin
        next_item = items_to_send.pop_front();
        op_i <= next_item.op;
        card_char_i <= next_item.ch;
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result must match the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (reports_due.size() == 0) begin
        $error("result with no prediction outstanding");
        errors++;
      end else begin
        due = reports_due.pop_front();
        check_field("echo_valid", 8'(due.echo_valid), 8'(echo_valid_o));
        check_field("echo_char", due.echo_char, echo_char_o);
        check_field("display_update", 8'(due.display_update), 8'(display_update_o));
        check_field("screen_code", 8'(due.screen_code), 8'(screen_code_o));
        check_field("event_code", 8'(due.event_code), 8'(event_code_o));
        check_field("admin_active", 8'(due.admin_active), 8'(admin_active_o));
        check_field("mode_now", 8'(due.mode_now), 8'(mode_now_o));
      end
    end
  end

  // Watchdog: give up when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o === 1'b1) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic push_item(input logic [1:0] op, input logic [7:0] ch);
    card_item_t it;
    it.op = op;
    it.ch = ch;
    items_to_send.push_back(it);
    items_queued++;
  endtask

  task automatic push_card(input card_id_t id);
    for (int unsigned p = 0; p < ID_LEN; p++) push_item(OP_CHAR, id[8*(ID_LEN-1-p) +: 8]);
  endtask

  task automatic push_random_chars(input int unsigned n);
    repeat (n) push_item(OP_CHAR, 8'($urandom_range(0, 255)));
  endtask

  task automatic push_ticks(input int unsigned n);
    repeat (n) push_item(OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  function automatic card_id_t random_card();
    card_id_t id;
    for (int unsigned p = 0; p < ID_LEN; p++) id[8*p +: 8] = 8'($urandom_range(0, 255));
    return id;
  endfunction

  // One well-formed access sequence with random content, or a burst of noise
  task automatic queue_scenario();
    int unsigned pick;
    int unsigned sub;
    card_id_t id;
    pick = $urandom_range(0, 99);
    // two presses bring any mode back to idle
    if ($urandom_range(0, 9) < 7) begin
      push_item(OP_BUTTON, 8'($urandom_range(0, 255)));
      push_item(OP_BUTTON, 8'($urandom_range(0, 255)));
    end
    if (pick < 40) begin
      push_card(ADMIN_ID);
      push_ticks(1);
      if ($urandom_range(0, 3) == 0) push_ticks($urandom_range(1, 3));
      push_item(OP_BUTTON, 8'($urandom_range(0, 255)));
      sub = $urandom_range(0, 9);
      if (sub < 4) begin
        id = random_card();
        card_pool.push_back(id);
        push_card(id);
      end else if (sub < 6) begin
        push_card(card_pool[$urandom_range(0, card_pool.size() - 1)]);
      end else if (sub < 7) begin
        push_random_chars($urandom_range(1, ID_LEN - 1));
      end else if (sub < 8) begin
        push_card(random_card());
        push_random_chars($urandom_range(1, 3));
      end else if (sub < 9) begin
        push_random_chars($urandom_range(1, ID_LEN));
        push_ticks($urandom_range(1, 3));
      end
      push_item(OP_BUTTON, 8'($urandom_range(0, 255)));
      push_ticks($urandom_range(0, 6));
    end else if (pick < 60) begin
      push_card(card_pool[$urandom_range(0, card_pool.size() - 1)]);
      push_ticks($urandom_range(1, 6));
      if ($urandom_range(0, 2) == 0) push_item(OP_BUTTON, 8'($urandom_range(0, 255)));
    end else if (pick < 75) begin
      push_card(random_card());
      push_ticks(1);
    end else begin
      repeat ($urandom_range(1, 8)) begin
        push_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Wait until every transfer is done and every result has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (items_to_send.size() != 0 || start_i || reports_due.size() != 0);
    repeat (TABLE_SIZE + 2) @(posedge clk_i);
  endtask

  task automatic write_tick_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_SESSION_TICKS) session_len = val;
    else message_len = val;
  endtask

  initial begin : stimulus
    int unsigned phase_end;
    logic [15:0] sess_val;
    logic [15:0] msg_val;
    cur_mode = MODE_IDLE;
    admin_on = 1'b0;
    id_buf = '0;
    id_len = 0;
    foreach (card_table[k]) card_table[k] = '0;
    card_table[0] = ADMIN_ID;
    card_table[1] = USER_ID;
    card_count = RESET_IDS;
    tick_left = '0;
    tick_done = 1'b0;
    shown = DISP_PROMPT;
    session_len = SESSION_TICKS_RST;
    message_len = MESSAGE_TICKS_RST;
    card_pool.push_back(ADMIN_ID);
    card_pool.push_back(USER_ID);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: unused op, extreme bytes, excess and dropped characters,
    // admin login, enrolment with a short ID, message expiry, empty enrol
    write_tick_reg(REG_SESSION_TICKS, 16'd2);
    write_tick_reg(REG_MESSAGE_TICKS, 16'd1);
    push_item(OP_UNUSED, 8'hFF);
    push_item(OP_CHAR, 8'h00);
    push_item(OP_BUTTON, 8'h00);
    push_card(ADMIN_ID);
    push_item(OP_CHAR, 8'hFF);
    push_item(OP_TICK, 8'h00);
    push_item(OP_CHAR, "x");
    push_item(OP_BUTTON, 8'h00);
    push_item(OP_CHAR, "1");
    push_item(OP_CHAR, "2");
    push_item(OP_BUTTON, 8'h00);
    push_item(OP_TICK, 8'h00);
    push_item(OP_BUTTON, 8'h00);
    push_item(OP_TICK, 8'h00);

    // Random phases, each under its own pair of tick settings
    for (int unsigned phase = 0; phase < 5; phase++) begin
      wait_drained();
      case (phase)
        0: begin sess_val = 16'd1;     msg_val = 16'd1;     end
        1: begin sess_val = 16'hFFFF;  msg_val = 16'd3;     end
        2: begin sess_val = 16'd4;     msg_val = 16'hFFFF;  end
        3: begin
          sess_val = 16'($urandom_range(2, 6));
          msg_val = 16'($urandom_range(1, 4));
        end
        default: begin
          sess_val = 16'($urandom_range(1, 8));
          msg_val = 16'd2;
        end
      endcase
      write_tick_reg(REG_SESSION_TICKS, sess_val);
      write_tick_reg(REG_MESSAGE_TICKS, msg_val);
      gaps_on = (phase != 3);
      phase_end = items_queued + 80;
      while (items_queued < phase_end) queue_scenario();
    end

    wait_drained();
    repeat (TABLE_SIZE + 4) @(posedge clk_i);
    if (reports_due.size() != 0) begin
      $error("%0d predicted results never arrived", reports_due.size());
      errors += reports_due.size();
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/cidac_pkg.sv
sv/cidac_cell.sv
sv/cidac_ctrl.sv
sv/card_id_access_controller.sv
tb/testbench.sv
